### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define RDC_ASSERT(label, ck, rn, prop, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error(msg);

// clocked check that also holds across reset
`define RDC_ASSERT_ALWAYS(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) else $error(msg);

`endif

### hdl/rdc_pkg.sv
// shared widths, division constants and types for the republican date converter
package rdc_pkg;

  // port payloads
  localparam int EPOCH_W     = 41;
  localparam int OFFSET_W    = 17;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // pipeline stage map
  localparam int NUM_STAGES   = 14;
  localparam int LAST_STAGE   = NUM_STAGES - 1;
  localparam int STG_SPLIT_LO = 1;
  localparam int STG_SPLIT_HI = 5;
  localparam int STG_DATE_LO  = 6;
  localparam int STG_DATE_HI  = 12;
  localparam int SPLIT_STAGES = STG_SPLIT_HI - STG_SPLIT_LO + 1;
  localparam int DATE_STAGES  = STG_DATE_HI - STG_DATE_LO + 1;

  // intermediate widths
  localparam int LOCAL_T_W = EPOCH_W + 1;
  localparam int ZDAY_W    = 25;
  localparam int TOD_W     = 17;
  localparam int YEAR_W    = 17;
  localparam int YDAY_W    = 9;
  localparam int MON_W     = 4;
  localparam int MDAY_W    = 5;
  localparam int DECADE_W  = 4;

  // day number = floor(t / 128) / 675, biased so the division is unsigned
  localparam logic [34:0] DAY_BIAS   = 35'd11324620800;  // 675 * 2^24
  localparam logic [9:0]  DIV_675    = 10'd675;
  localparam logic [19:0] RECIP_HI   = 20'd795365;       // 2^29 / 675, rounded up
  localparam logic [26:0] RECIP_LO   = 27'd101806633;    // 2^36 / 675, rounded up
  // biased day to biased civil day: + 719468 + 100 eras - 2^24
  localparam logic [25:0] ZDAY_SUB   = 26'd1448048;

  // 400-year era split
  localparam logic [25:0] RECIP_ERA  = 26'd60207212;     // 2^43 / 146097, rounded up
  localparam logic [17:0] ERA_DAYS   = 18'd146097;
  localparam logic [18:0] RECIP_1460 = 19'd367720;       // 2^29 / 1460, rounded up
  localparam logic [18:0] RECIP_365  = 19'd367720;       // 2^27 / 365, rounded up
  localparam logic [17:0] DAYS_4C_M1 = 18'd146096;
  localparam logic [17:0] DAYS_1C    = 18'd36524;
  localparam logic [17:0] DAYS_2C    = 18'd73048;
  localparam logic [17:0] DAYS_3C    = 18'd109572;
  localparam logic [17:0] DAYS_YEAR  = 18'd365;
  localparam logic [8:0]  YOE_100    = 9'd100;
  localparam logic [8:0]  YOE_200    = 9'd200;
  localparam logic [8:0]  YOE_300    = 9'd300;

  // new year on 22 September: day 205 of a March-based year
  localparam logic [8:0]  NEWYEAR_DOY  = 9'd205;
  localparam logic [8:0]  PRE_NY_DAYS  = 9'd161;
  localparam logic [16:0] ERA_YEARS    = 17'd400;
  localparam logic [16:0] YEAR_BASE    = 17'd41791;  // 100 eras + 1791

  // thirty-day months and ten-day weeks
  localparam logic [9:0]  RECIP_30   = 10'd547;         // 2^14 / 30, rounded up
  localparam logic [8:0]  MONTH_DAYS = 9'd30;
  localparam logic [4:0]  DECADE_1   = 5'd10;
  localparam logic [4:0]  DECADE_2   = 5'd20;
  localparam logic [4:0]  DECADE_3   = 5'd30;

  // time of day
  localparam logic [17:0] RECIP_60S  = 18'd139811;      // 2^23 / 60, rounded up
  localparam logic [11:0] RECIP_60M  = 12'd2185;        // 2^17 / 60, rounded up
  localparam logic [16:0] SIXTY      = 17'd60;
  localparam int          HMS_DLY    = 4;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    logic [YEAR_W-1:0] rep_year;
    logic [YDAY_W-1:0] yday;
    logic [MON_W-1:0]  mon0;   // month minus one
  } date_t;

endpackage

### hdl/rdc_day_split.sv
// stages 1..5: local time, floor split into biased day number and time of day
module rdc_day_split (
  input  logic                                clk,
  input  logic [rdc_pkg::SPLIT_STAGES-1:0]    en,
  input  logic signed [rdc_pkg::EPOCH_W-1:0]  epoch,
  input  logic signed [rdc_pkg::OFFSET_W-1:0] offset,
  output logic [rdc_pkg::ZDAY_W-1:0]          zday,
  output logic [rdc_pkg::TOD_W-1:0]           tod
);
  import rdc_pkg::*;

  logic signed [LOCAL_T_W-1:0] local_t;
  logic [34:0] s1_q1u_nxt, s1_q1u_r;
  logic [6:0]  s1_r7_r;
  logic [38:0] hi_prod;
  logic [9:0]  s2_qh_r;
  logic [18:0] s2_hi_r;
  logic [15:0] s2_lo_r;
  logic [6:0]  s2_r7_r;
  logic [18:0] qh_mul;
  logic [9:0]  s3_rh_nxt, s3_rh_r, s3_qh_r;
  logic [15:0] s3_lo_r;
  logic [6:0]  s3_r7_r;
  logic [25:0] n2;
  logic [52:0] lo_prod;
  logic [15:0] s4_ql_r;
  logic [25:0] s4_n2_r;
  logic [9:0]  s4_qh_r;
  logic [6:0]  s4_r7_r;
  logic [25:0] ql_mul, day_u;
  logic [9:0]  rq;
  logic [ZDAY_W-1:0] s5_zday_nxt, s5_zday_r;
  logic [TOD_W-1:0]  s5_tod_r;

  // stage 1: add offset, floor divide by 128, bias positive
  assign local_t    = LOCAL_T_W'(epoch) + LOCAL_T_W'(offset);
  assign s1_q1u_nxt = local_t[LOCAL_T_W-1:7] + DAY_BIAS;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_q1u_r <= s1_q1u_nxt;
      s1_r7_r  <= local_t[6:0];
    end
  end

  // stage 2: quotient of the upper 19 bits by 675
  assign hi_prod = 39'(s1_q1u_r[34:16]) * 39'(RECIP_HI);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_qh_r <= hi_prod[38:29];
      s2_hi_r <= s1_q1u_r[34:16];
      s2_lo_r <= s1_q1u_r[15:0];
      s2_r7_r <= s1_r7_r;
    end
  end

  // stage 3: remainder of the upper part
  assign qh_mul    = 19'(s2_qh_r) * 19'(DIV_675);
  assign s3_rh_nxt = 10'(s2_hi_r - qh_mul);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_rh_r <= s3_rh_nxt;
      s3_qh_r <= s2_qh_r;
      s3_lo_r <= s2_lo_r;
      s3_r7_r <= s2_r7_r;
    end
  end

  // stage 4: quotient of remainder:lower bits by 675
  assign n2      = {s3_rh_r, s3_lo_r};
  assign lo_prod = 53'(n2) * 53'(RECIP_LO);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_ql_r <= lo_prod[51:36];
      s4_n2_r <= n2;
      s4_qh_r <= s3_qh_r;
      s4_r7_r <= s3_r7_r;
    end
  end

  // stage 5: day remainder gives time of day, shift day to civil base
  assign ql_mul      = 26'(s4_ql_r) * 26'(DIV_675);
  assign rq          = 10'(s4_n2_r - ql_mul);
  assign day_u       = {s4_qh_r, s4_ql_r};
  assign s5_zday_nxt = ZDAY_W'(day_u - ZDAY_SUB);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_zday_r <= s5_zday_nxt;
      s5_tod_r  <= {rq, s4_r7_r};
    end
  end

  assign zday = s5_zday_r;
  assign tod  = s5_tod_r;

endmodule

### hdl/rdc_tod_split.sv
// stages 6..12: hour, minute and second of the local time of day
module rdc_tod_split (
  input  logic                            clk,
  input  logic [rdc_pkg::DATE_STAGES-1:0] en,
  input  logic [rdc_pkg::TOD_W-1:0]       tod,
  output rdc_pkg::hms_t                   hms
);
  import rdc_pkg::*;

  logic [34:0] m_prod;
  logic [10:0] s6_mt_r;
  logic [TOD_W-1:0] s6_tod_r;
  logic [16:0] mt_mul;
  logic [22:0] h_prod;
  logic [5:0]  s7_sec_nxt, s7_sec_r;
  logic [4:0]  s7_hour_r;
  logic [10:0] s7_mt_r;
  logic [10:0] hour_mul;
  hms_t        s8_hms_nxt, s8_hms_r;
  hms_t        hms_dly_r [HMS_DLY];

  // stage 6: minutes of the day
  assign m_prod = 35'(tod) * 35'(RECIP_60S);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s6_mt_r  <= m_prod[33:23];
      s6_tod_r <= tod;
    end
  end

  // stage 7: seconds and hours
  assign mt_mul     = 17'(s6_mt_r) * SIXTY;
  assign s7_sec_nxt = 6'(s6_tod_r - mt_mul);
  assign h_prod     = 23'(s6_mt_r) * 23'(RECIP_60M);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s7_sec_r  <= s7_sec_nxt;
      s7_hour_r <= h_prod[21:17];
      s7_mt_r   <= s6_mt_r;
    end
  end

  // stage 8: minutes of the hour
  assign hour_mul          = 11'(s7_hour_r) * 11'(SIXTY);
  assign s8_hms_nxt.hour   = s7_hour_r;
  assign s8_hms_nxt.minute = 6'(s7_mt_r - hour_mul);
  assign s8_hms_nxt.second = s7_sec_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s8_hms_r <= s8_hms_nxt;
    end
  end

  // stages 9..12: line up with the date path
  always_ff @(posedge clk) begin
    if (en[3]) begin
      hms_dly_r[0] <= s8_hms_r;
    end
  end

  for (genvar g = 1; g < HMS_DLY; g++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[3 + g]) begin
        hms_dly_r[g] <= hms_dly_r[g - 1];
      end
    end
  end

  assign hms = hms_dly_r[HMS_DLY - 1];

endmodule

### hdl/rdc_civil_date.sv
// stages 6..12: gregorian era split and republican year, day of year, month
module rdc_civil_date (
  input  logic                            clk,
  input  logic [rdc_pkg::DATE_STAGES-1:0] en,
  input  logic [rdc_pkg::ZDAY_W-1:0]      zday,
  output rdc_pkg::date_t                  date
);
  import rdc_pkg::*;

  logic [50:0] era_prod;
  logic [7:0]  s6_era_r, s7_era_r, s8_era_r, s9_era_r, s10_era_r;
  logic [ZDAY_W-1:0] s6_zday_r;
  logic [ZDAY_W-1:0] era_mul;
  logic [17:0] s7_doe_nxt, s7_doe_r, s8_doe_r, s9_doe_r;
  logic [36:0] c4y_prod;
  logic [7:0]  n4y;
  logic [2:0]  ncent;
  logic        nera;
  logic [17:0] s8_yacc_nxt, s8_yacc_r;
  logic [36:0] yoe_prod;
  logic [8:0]  s9_yoe_r, s10_yoe_r;
  logic [1:0]  cent;
  logic [17:0] yr_days;
  logic [8:0]  s10_doy_nxt, s10_doy_r;
  logic        s10_leap_nxt, s10_leap_r;
  logic        before_ny;
  logic [8:0]  s11_yday_nxt, s11_yday_r, s12_yday_r;
  logic [16:0] s11_year_nxt, s11_year_r, s12_year_r;
  logic [18:0] mon_prod;
  logic [3:0]  s12_m0_r;

  // stage 6: era number (biased by 100 eras)
  assign era_prod = 51'(zday) * 51'(RECIP_ERA);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s6_era_r  <= era_prod[50:43];
      s6_zday_r <= zday;
    end
  end

  // stage 7: day of era
  assign era_mul    = ZDAY_W'(s6_era_r) * ZDAY_W'(ERA_DAYS);
  assign s7_doe_nxt = 18'(s6_zday_r - era_mul);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s7_doe_r <= s7_doe_nxt;
      s7_era_r <= s6_era_r;
    end
  end

  // stage 8: drop leap days so a plain divide by 365 gives the year
  assign c4y_prod    = 37'(s7_doe_r) * 37'(RECIP_1460);
  assign n4y         = c4y_prod[36:29];
  assign ncent       = 3'(s7_doe_r >= DAYS_1C) + 3'(s7_doe_r >= DAYS_2C)
                     + 3'(s7_doe_r >= DAYS_3C) + 3'(s7_doe_r >= DAYS_4C_M1);
  assign nera        = (s7_doe_r == DAYS_4C_M1);
  assign s8_yacc_nxt = s7_doe_r - 18'(n4y) + 18'(ncent) - 18'(nera);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s8_yacc_r <= s8_yacc_nxt;
      s8_doe_r  <= s7_doe_r;
      s8_era_r  <= s7_era_r;
    end
  end

  // stage 9: year of era
  assign yoe_prod = 37'(s8_yacc_r) * 37'(RECIP_365);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s9_yoe_r <= yoe_prod[35:27];
      s9_doe_r <= s8_doe_r;
      s9_era_r <= s8_era_r;
    end
  end

  // stage 10: day of the march-based year, leap flag of the preceding february
  assign cent    = 2'(s9_yoe_r >= YOE_100) + 2'(s9_yoe_r >= YOE_200)
                 + 2'(s9_yoe_r >= YOE_300);
  assign yr_days = 18'(s9_yoe_r) * DAYS_YEAR + 18'(s9_yoe_r[8:2]) - 18'(cent);
  assign s10_doy_nxt  = 9'(s9_doe_r - yr_days);
  assign s10_leap_nxt = (s9_yoe_r[1:0] == 2'b00) && (s9_yoe_r != YOE_100)
                     && (s9_yoe_r != YOE_200) && (s9_yoe_r != YOE_300);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s10_doy_r  <= s10_doy_nxt;
      s10_leap_r <= s10_leap_nxt;
      s10_yoe_r  <= s9_yoe_r;
      s10_era_r  <= s9_era_r;
    end
  end

  // stage 11: republican year and day of year around 22 september
  assign before_ny    = (s10_doy_r < NEWYEAR_DOY);
  assign s11_yday_nxt = before_ny ? s10_doy_r + PRE_NY_DAYS + 9'(s10_leap_r)
                                  : s10_doy_r - (NEWYEAR_DOY - 9'd1);
  assign s11_year_nxt = 17'(s10_era_r) * ERA_YEARS + 17'(s10_yoe_r)
                      - 17'(before_ny) - YEAR_BASE;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s11_yday_r <= s11_yday_nxt;
      s11_year_r <= s11_year_nxt;
    end
  end

  // stage 12: month index
  assign mon_prod = 19'(s11_yday_r - 9'd1) * 19'(RECIP_30);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s12_m0_r   <= mon_prod[17:14];
      s12_yday_r <= s11_yday_r;
      s12_year_r <= s11_year_r;
    end
  end

  assign date.rep_year = s12_year_r;
  assign date.yday     = s12_yday_r;
  assign date.mon0     = s12_m0_r;

endmodule

### hdl/republican_date_convert_unit.sv
// top level of the republican date converter
//
// converts a signed 41-bit count of utc seconds since 1970 into the french
// republican date and the local time of day
// - input stream (in_*): one transaction carries epoch_seconds
// - output stream (out_*): one transaction per input, same order
// - cfg_wr_en / cfg_wr_data load the signed utc offset in seconds; write it
//   only while no transaction is in flight
// - fourteen register stages: the input register, the day split stages, the
//   date and time split stages and the output register
// - one transaction per cycle sustained while out_tready is high; every stage
//   has its own valid bit and loads whenever out_tready is high or it or
//   something downstream is empty, so bubbles close up even while the output waits
// - a stall on out_tready holds the output register; in_tready drops only
//   once every stage holds a transaction
// - reset empties the pipeline and sets the offset to zero; payload
//   registers are not reset
// - the day split is a floor divide by 86400 done as a shift by 7 and two
//   reciprocal divides by 675; the 400-year era split follows
module republican_date_convert_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rdc_pkg::IN_TDATA_W-1:0]       in_tdata,   // [40:0] epoch_seconds
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [16:0] rep_year, [25:17] day_of_year, [29:26] rep_month, [34:30] rep_day,
  // [38:35] decade_day, [43:39] hour, [49:44] minute, [55:50] second
  output logic [rdc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [rdc_pkg::OFFSET_W-1:0]         cfg_wr_data // utc_offset_seconds
);
  import rdc_pkg::*;

  logic [LAST_STAGE:0]          en;
  logic [LAST_STAGE:0]          vld_r;
  logic signed [EPOCH_W-1:0]    epoch_r;
  logic signed [OFFSET_W-1:0]   offset_r;
  logic [ZDAY_W-1:0]            zday;
  logic [TOD_W-1:0]             tod;
  date_t                        date;
  hms_t                         hms;
  logic [MON_W-1:0]             mon;
  logic [MDAY_W-1:0]            mday;
  logic [DECADE_W-1:0]          decade;
  logic [OUT_TDATA_W-1:0]       out_tdata_nxt, out_tdata_r;

  // a stage may load when out_tready is high or it or any stage after it is empty
  for (genvar g = 0; g <= LAST_STAGE; g++) begin : g_en
    assign en[g] = out_tready || !(&vld_r[LAST_STAGE:g]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en[0]) begin
      vld_r[0] <= in_tvalid;
    end
  end

  for (genvar g = 1; g <= LAST_STAGE; g++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en[g]) begin
        vld_r[g] <= vld_r[g - 1];
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[LAST_STAGE];

  // offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_wr_en) begin
      offset_r <= cfg_wr_data;
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      epoch_r <= in_tdata[EPOCH_W-1:0];
    end
  end

  rdc_day_split u_day_split (
    .clk    (clk),
    .en     (en[STG_SPLIT_HI:STG_SPLIT_LO]),
    .epoch  (epoch_r),
    .offset (offset_r),
    .zday   (zday),
    .tod    (tod)
  );

  rdc_civil_date u_civil_date (
    .clk  (clk),
    .en   (en[STG_DATE_HI:STG_DATE_LO]),
    .zday (zday),
    .date (date)
  );

  rdc_tod_split u_tod_split (
    .clk (clk),
    .en  (en[STG_DATE_HI:STG_DATE_LO]),
    .tod (tod),
    .hms (hms)
  );

  // last stage: day of month and decade day, then pack the output word
  assign mon  = date.mon0 + MON_W'(1);
  assign mday = MDAY_W'(date.yday - 9'(date.mon0) * MONTH_DAYS);

  always_comb begin
    if (mday >= DECADE_3) begin
      decade = DECADE_W'(mday - DECADE_3);
    end else if (mday >= DECADE_2) begin
      decade = DECADE_W'(mday - DECADE_2);
    end else if (mday >= DECADE_1) begin
      decade = DECADE_W'(mday - DECADE_1);
    end else begin
      decade = DECADE_W'(mday);
    end
  end

  assign out_tdata_nxt = {hms.second, hms.minute, hms.hour, decade, mday, mon,
                          date.yday, date.rep_year};

  always_ff @(posedge clk) begin
    if (en[LAST_STAGE]) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

### hdl/rdc_checker.sv
// port-level checks for the republican date converter, bound to the top level
`include "assert_macros.svh"

module rdc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rdc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rdc_pkg::*;

  logic [8:0] chk_doy;
  logic [3:0] chk_mon;
  logic [4:0] chk_mday;
  logic [4:0] chk_hour;
  logic [5:0] chk_min;
  logic [5:0] chk_sec;

  assign chk_doy  = out_tdata[25:17];
  assign chk_mon  = out_tdata[29:26];
  assign chk_mday = out_tdata[34:30];
  assign chk_hour = out_tdata[43:39];
  assign chk_min  = out_tdata[49:44];
  assign chk_sec  = out_tdata[55:50];

  // reset leaves nothing to deliver
  `RDC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // a waiting result is held until taken
  `RDC_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "output changed while stalled")

  // with nothing at the output the pipeline must take input
  `RDC_ASSERT(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty output")

  // month and day of month agree with the day of year
  `RDC_ASSERT(a_date_consistent, clk, rst_n, out_tvalid |-> chk_doy == 9'(chk_mon) * MONTH_DAYS - MONTH_DAYS + 9'(chk_mday), "month/day disagree with day of year")

  // time of day fields in range
  `RDC_ASSERT(a_time_range, clk, rst_n, out_tvalid |-> chk_hour < 5'd24 && chk_min < 6'd60 && chk_sec < 6'd60, "time of day out of range")

endmodule

bind republican_date_convert_unit rdc_checker u_rdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### verif/tb_republican_date_convert_unit.sv
// self-checking testbench for the republican date converter
`timescale 1ns / 1ps

module tb_republican_date_convert_unit;
  import rdc_pkg::*;

  localparam longint SECS_PER_DAY   = 86400;
  localparam longint FIRST_REP_YEAR = 1792;
  localparam longint NEWYEAR_MONTH  = 9;
  localparam longint NEWYEAR_DAY    = 22;
  localparam longint MONTH_LEN      = 30;
  localparam longint DECADE_LEN     = 10;
  localparam int     NUM_PHASES     = 7;
  localparam int     RANDOM_PER_PHASE = 200;
  localparam int     LIMIT_CYCLES   = 200000;

  typedef struct packed {
    logic signed [16:0] rep_year;
    logic [8:0]         yday;
    logic [3:0]         month;
    logic [4:0]         mday;
    logic [3:0]         decade;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
  } rep_stamp_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [OFFSET_W-1:0]    cfg_wr_data = '0;

  logic [EPOCH_W-1:0] pending_epochs[$];
  rep_stamp_t         expected_dates[$];
  longint             offset_now = 0;
  int                 in_idle_pct = 0;
  int                 out_stall_pct = 0;
  int                 in_gap = 0;
  int                 out_stall = 0;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;

  republican_date_convert_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // days since 1970-01-01 of a proleptic gregorian date
  function automatic longint days_from_civil(input longint y_in, input longint m,
                                             input longint d);
    longint y, era, yoe, doy, doe;
    y = (m <= 2) ? y_in - 1 : y_in;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic void civil_from_days(input longint z_in, output longint y,
                                          output longint m, output longint d);
    longint z, era, doe, yoe, doy, mp;
    z = z_in + 719468;
    era = (z >= 0 ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = mp < 10 ? mp + 3 : mp - 9;
    y = yoe + era * 400 + (m <= 2 ? 1 : 0);
  endfunction

  // republican date and local time for one timestamp under a given offset
  function automatic rep_stamp_t republican_of_epoch(input logic [EPOCH_W-1:0] epoch,
                                                     input longint offs);
    longint t, day, tod, gy, gm, gd, start_y, yr, yday, mon, mday;
    rep_stamp_t r;
    t = longint'($signed(epoch)) + offs;
    day = t / SECS_PER_DAY;
    tod = t % SECS_PER_DAY;
    // floor toward minus infinity
    if (tod < 0) begin
      tod += SECS_PER_DAY;
      day -= 1;
    end
    civil_from_days(day, gy, gm, gd);
    start_y = (gm < NEWYEAR_MONTH || (gm == NEWYEAR_MONTH && gd < NEWYEAR_DAY)) ?
              gy - 1 : gy;
    yr = start_y + 1 - FIRST_REP_YEAR;
    yday = day - days_from_civil(start_y, NEWYEAR_MONTH, NEWYEAR_DAY) + 1;
    mon = (yday - 1) / MONTH_LEN + 1;
    mday = yday - (mon - 1) * MONTH_LEN;
    r.rep_year = yr[16:0];
    r.yday     = yday[8:0];
    r.month    = mon[3:0];
    r.mday     = mday[4:0];
    r.decade   = 4'(mday % DECADE_LEN);
    r.hour     = 5'(tod / 3600);
    r.minute   = 6'((tod / 60) % 60);
    r.second   = 6'(tod % 60);
    return r;
  endfunction

  function automatic void check_field(input string name, input longint exp_v,
                                      input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // driver: presents queued timestamps, records the expected date on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_dates.push_back(republican_of_epoch(in_tdata[EPOCH_W-1:0], offset_now));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (pending_epochs.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_TDATA_W - EPOCH_W){1'b0}}, pending_epochs.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each output transaction against the oldest expected date
  always @(posedge clk) begin
    rep_stamp_t exp_d;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_dates.size() == 0) begin
          $error("output transaction with no expected date: %h", out_tdata);
          mismatch_count++;
        end else begin
          exp_d = expected_dates.pop_front();
          check_field("rep_year", exp_d.rep_year, longint'($signed(out_tdata[16:0])));
          check_field("day_of_year", exp_d.yday, out_tdata[25:17]);
          check_field("rep_month", exp_d.month, out_tdata[29:26]);
          check_field("rep_day", exp_d.mday, out_tdata[34:30]);
          check_field("decade_day", exp_d.decade, out_tdata[38:35]);
          check_field("hour", exp_d.hour, out_tdata[43:39]);
          check_field("minute", exp_d.minute, out_tdata[49:44]);
          check_field("second", exp_d.second, out_tdata[55:50]);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_republican_date_convert_unit failed");
      $finish;
    end
  end

  // hold the sender until the pipeline has fully drained
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_epochs.size() != 0 || in_tvalid || expected_dates.size() != 0);
  endtask

  task automatic queue_secs(input longint secs);
    pending_epochs.push_back(secs[EPOCH_W-1:0]);
  endtask

  initial begin
    longint phase_offset[NUM_PHASES] = '{0, 65535, -65536, 50400, -50400, 0, 0};
    int     phase_in_pct[NUM_PHASES]  = '{20, 0, 35, 10, 50, 15, 0};
    int     phase_out_pct[NUM_PHASES] = '{20, 30, 0, 45, 10, 25, 0};
    int     bnd_month[6] = '{9, 9, 2, 3, 1, 12};
    int     bnd_day[6]   = '{21, 22, 29, 1, 1, 31};
    logic [63:0] rnd;
    longint secs, yr, tod, v;
    int     k;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        v = (ph == 5) ? longint'($urandom_range(0, 131071)) - 65536 : phase_offset[ph];
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[OFFSET_W-1:0];
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        offset_now = v;
        @(negedge clk);
      end
      in_idle_pct   = phase_in_pct[ph];
      out_stall_pct = phase_out_pct[ph];

      if (ph == 0) begin
        // epoch, negative times and day edges
        queue_secs(0);
        queue_secs(-1);
        queue_secs(86399);
        queue_secs(86400);
        queue_secs(-86400);
        queue_secs(-86401);
        queue_secs(1);
        // extremes of the 41-bit input
        queue_secs((longint'(1) << 40) - 1);
        queue_secs(-(longint'(1) << 40));
        queue_secs(longint'(1) << 39);
        queue_secs(-(longint'(1) << 39) - 1);
        // first republican new year and the day before
        queue_secs(days_from_civil(1792, 9, 22) * SECS_PER_DAY);
        queue_secs(days_from_civil(1792, 9, 22) * SECS_PER_DAY - 1);
        // last complementary day: leap and common years
        queue_secs(days_from_civil(1792, 9, 21) * SECS_PER_DAY);
        queue_secs(days_from_civil(1793, 9, 21) * SECS_PER_DAY);
        queue_secs(days_from_civil(1900, 9, 21) * SECS_PER_DAY);
        queue_secs(days_from_civil(2000, 9, 21) * SECS_PER_DAY + 43200);
        // month edges: tenth decade day, month rollover, into month 13
        queue_secs(days_from_civil(1793, 10, 21) * SECS_PER_DAY);
        queue_secs(days_from_civil(1793, 10, 22) * SECS_PER_DAY);
        queue_secs(days_from_civil(1794, 9, 16) * SECS_PER_DAY);
        queue_secs(days_from_civil(1794, 9, 17) * SECS_PER_DAY);
        queue_secs(days_from_civil(2024, 2, 29) * SECS_PER_DAY + 86399);
        queue_secs(days_from_civil(1971, 1, 1) * SECS_PER_DAY - 1);
        // far negative years
        queue_secs(days_from_civil(-20000, 9, 22) * SECS_PER_DAY);
        queue_secs(days_from_civil(-20000, 9, 21) * SECS_PER_DAY + 43200);
      end

      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        rnd = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
          0: secs = longint'($signed(rnd[EPOCH_W-1:0]));
          1: secs = longint'($signed(rnd[33:0]));
          default: begin
            // land near a new year, leap day or calendar year edge in local time
            yr = longint'($urandom_range(0, 60000)) - 28000;
            k = $urandom_range(0, 5);
            case ($urandom_range(0, 2))
              0: tod = 0;
              1: tod = SECS_PER_DAY - 1;
              default: tod = longint'($urandom_range(0, 86399));
            endcase
            secs = days_from_civil(yr, bnd_month[k], bnd_day[k]) * SECS_PER_DAY + tod
                   - offset_now;
          end
        endcase
        queue_secs(secs);
      end
    end

    wait_drained();
    repeat (NUM_STAGES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_republican_date_convert_unit passed");
    end else begin
      $display("tb_republican_date_convert_unit failed");
    end
    $finish;
  end

endmodule
